FILE: hw/rtl/swmm_pkg.sv
// shared types and command codes for the sliding window min/max/mean block
`timescale 1ns / 1ps

package swmm_pkg;

  localparam int unsigned CodeBits = 12;
  localparam int unsigned MeanBits = 16;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  typedef struct packed {
    logic                cmd;
    logic [CodeBits-1:0] sample_code;
  } swmm_in_t;

  typedef struct packed {
    logic [MeanBits-1:0] mean_code;
    logic [CodeBits-1:0] max_code;
    logic [CodeBits-1:0] min_code;
  } swmm_out_t;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } swmm_state_e;

endpackage

FILE: hw/rtl/swmm_cell.sv
// one window cell: holds a code and loads its neighbor's code when the chain moves
`timescale 1ns / 1ps

module swmm_cell #(
  parameter int unsigned WIDTH = 12
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             move_i,
  input  logic [WIDTH-1:0] d_i,
  output logic [WIDTH-1:0] q_o
);

  logic [WIDTH-1:0] code_q;
  logic [WIDTH-1:0] code_d;

  assign code_d = move_i ? d_i : code_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_q <= '0;
    end else begin
      code_q <= code_d;
    end
  end

  assign q_o = code_q;

endmodule

FILE: hw/rtl/swmm_mean.sv
// mean unit: window sum times 16 divided by the depth, saturated to 16 bits
`timescale 1ns / 1ps

module swmm_mean #(
  parameter int unsigned WINDOW_DEPTH = 16,
  parameter int unsigned SAMPLE_BITS  = 12
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic [SAMPLE_BITS+$clog2(WINDOW_DEPTH)-1:0]   sum_i,
  output logic [swmm_pkg::MeanBits-1:0]                 mean_o
);

  localparam int unsigned SumW = SAMPLE_BITS + $clog2(WINDOW_DEPTH);
  localparam int unsigned XW   = SumW + 4;
  localparam int unsigned MW   = swmm_pkg::MeanBits;

  logic [XW-1:0] x;
  logic [XW-1:0] quot;
  logic [XW+MW-1:0] quot_pad;
  logic [MW-1:0] mean_q;
  logic [MW-1:0] mean_d;

  // scale by 16 for the four fraction bits
  assign x = {sum_i, 4'b0000};

  if ((WINDOW_DEPTH & (WINDOW_DEPTH - 1)) == 0) begin : g_pow2
    assign quot = x >> $clog2(WINDOW_DEPTH);
  end else begin : g_recip
    localparam longint unsigned RecipL = (64'd1 << XW) / WINDOW_DEPTH;
    localparam logic [XW-1:0] Recip = XW'(RecipL);
    localparam logic [XW-1:0] Depth = XW'(WINDOW_DEPTH);

    logic [2*XW-1:0] prod_q;
    logic [XW-1:0]   x1_q;
    logic [XW-1:0]   x2_q;
    logic [XW-1:0]   qe_q;
    logic [XW-1:0]   qd_q;
    logic [XW-1:0]   rem;
    logic [XW-1:0]   qe_next;
    logic [2*XW-1:0] qd_full;

    // estimate is the true quotient or one below it
    assign qe_next = prod_q[2*XW-1:XW];
    assign qd_full = {{XW{1'b0}}, qe_next} * {{XW{1'b0}}, Depth};
    assign rem     = x2_q - qd_q;
    assign quot    = (rem >= Depth) ? qe_q + XW'(1) : qe_q;

    always_ff @(posedge clk_i) begin
      prod_q <= {{XW{1'b0}}, x} * {{XW{1'b0}}, Recip};
      x1_q   <= x;
      x2_q   <= x1_q;
      qe_q   <= qe_next;
      qd_q   <= qd_full[XW-1:0];
    end
  end

  assign quot_pad = {{MW{1'b0}}, quot};
  assign mean_d   = (|quot_pad[XW+MW-1:MW]) ? {MW{1'b1}} : quot_pad[MW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mean_q <= '0;
    end else begin
      mean_q <= mean_d;
    end
  end

  assign mean_o = mean_q;

endmodule

FILE: hw/rtl/sliding_window_min_max_mean.sv
// top level: sample window as a chain of cells, scan control, mean unit
`timescale 1ns / 1ps

// Keeps the last WINDOW_DEPTH clamped converter codes (zeros after reset) in
// a chain of cells. A sample word (cmd 0) gives no result: codes of full
// scale minus one or more are stored as full scale. A query word (cmd 1) gives
// one result with the mean in 12.4 fixed point (sum * 16 / WINDOW_DEPTH,
// saturated at 65535), the maximum and the minimum. A query holds off the
// input while the chain rotates once past cell zero, where the running max/min
// are updated, and while the mean unit's pipeline settles. The result sits in
// an output register; a sample word may be taken while it waits, a following
// query waits at its last step until the register is free.
module sliding_window_min_max_mean #(
  parameter int unsigned WINDOW_DEPTH = 16,
  parameter int unsigned SAMPLE_BITS  = 12
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  swmm_pkg::swmm_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output swmm_pkg::swmm_out_t out_data_o
);

  localparam int unsigned SB    = SAMPLE_BITS;
  localparam int unsigned CB    = swmm_pkg::CodeBits;
  localparam int unsigned SumW  = SB + $clog2(WINDOW_DEPTH);
  localparam int unsigned QCyc  = (WINDOW_DEPTH > 4) ? WINDOW_DEPTH : 4;
  localparam int unsigned CntW  = $clog2(QCyc);
  localparam logic [CntW-1:0] CntLast = CntW'(QCyc - 1);
  localparam logic [SB-1:0] FullScale = {SB{1'b1}};
  localparam logic [SB-1:0] ClampLvl  = {{(SB-1){1'b1}}, 1'b0};
  localparam logic [SumW-1:0] SumMax  = SumW'(WINDOW_DEPTH * ((2 ** SB) - 1));

  swmm_pkg::swmm_state_e state_q, state_d;

  logic [SB-1:0] cell_q [WINDOW_DEPTH];
  logic [SB-1:0] cell_d [WINDOW_DEPTH];

  logic [SB+CB-1:0] code_pad;
  logic [SB-1:0]    code_raw;
  logic [SB-1:0]    code_clamp;

  logic [SumW-1:0] sum_q, sum_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [SB-1:0]   max_q, max_d;
  logic [SB-1:0]   min_q, min_d;
  logic [swmm_pkg::MeanBits-1:0] mean;

  logic accept;
  logic take_sample;
  logic take_query;
  logic rot_en;
  logic move;
  logic at_last;
  logic load;

  swmm_pkg::swmm_out_t out_q, out_d;
  logic out_valid_q, out_valid_d;
  logic [SB+CB-1:0] max_pad;
  logic [SB+CB-1:0] min_pad;

  assign accept      = in_valid_i && in_ready_o;
  assign take_sample = accept && (in_data_i.cmd == swmm_pkg::CMD_SAMPLE);
  assign take_query  = accept && (in_data_i.cmd == swmm_pkg::CMD_QUERY);
  assign at_last     = (cnt_q == CntLast);

  // mask the input code to the cell width, then clamp near full scale
  assign code_pad   = {{SB{1'b0}}, in_data_i.sample_code};
  assign code_raw   = code_pad[SB-1:0];
  assign code_clamp = (code_raw >= ClampLvl) ? FullScale : code_raw;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      swmm_pkg::ST_IDLE: begin
        if (take_query) begin
          state_d = swmm_pkg::ST_SCAN;
        end
      end
      swmm_pkg::ST_SCAN: begin
        if (load) begin
          state_d = swmm_pkg::ST_IDLE;
        end
      end
      default: state_d = swmm_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready_o = 1'b0;
    rot_en     = 1'b0;
    load       = 1'b0;
    case (state_q)
      swmm_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
      end
      swmm_pkg::ST_SCAN: begin
        load   = at_last && (!out_valid_q || out_ready_i);
        // the last step of the rotation waits with the result register
        rot_en = ({1'b0, cnt_q} < (CntW + 1)'(WINDOW_DEPTH)) && (!at_last || load);
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  assign move = take_sample || rot_en;

  // chain wiring: cell zero holds the oldest code
  always_comb begin
    for (int k = 0; k < WINDOW_DEPTH - 1; k++) begin
      cell_d[k] = cell_q[k+1];
    end
    cell_d[WINDOW_DEPTH-1] = rot_en ? cell_q[0] : code_clamp;
  end

  for (genvar g = 0; g < WINDOW_DEPTH; g++) begin : g_cell
    swmm_cell #(
      .WIDTH (SB)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .move_i (move),
      .d_i    (cell_d[g]),
      .q_o    (cell_q[g])
    );
  end

  assign sum_d = take_sample
               ? sum_q - {{(SumW-SB){1'b0}}, cell_q[0]} + {{(SumW-SB){1'b0}}, code_clamp}
               : sum_q;

  // running max/min over the code passing cell zero
  always_comb begin
    max_d = max_q;
    min_d = min_q;
    cnt_d = cnt_q;
    if (take_query) begin
      max_d = '0;
      min_d = FullScale;
      cnt_d = '0;
    end else begin
      if (rot_en) begin
        if (cell_q[0] > max_q) begin
          max_d = cell_q[0];
        end
        if (cell_q[0] < min_q) begin
          min_d = cell_q[0];
        end
      end
      if ((state_q == swmm_pkg::ST_SCAN) && !at_last) begin
        cnt_d = cnt_q + CntW'(1);
      end
    end
  end

  swmm_mean #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_mean (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sum_i  (sum_q),
    .mean_o (mean)
  );

  assign max_pad = {{CB{1'b0}}, max_d};
  assign min_pad = {{CB{1'b0}}, min_d};

  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (load) begin
      out_d.mean_code = mean;
      out_d.max_code  = max_pad[CB-1:0];
      out_d.min_code  = min_pad[CB-1:0];
      out_valid_d     = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= swmm_pkg::ST_IDLE;
      sum_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sum_q       <= sum_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    max_q <= max_d;
    min_q <= min_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_sum_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sum_q <= SumMax)
    else $error("window sum above its largest possible value");

  a_scan_keeps_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == swmm_pkg::ST_SCAN) |=> $stable(sum_q))
    else $error("window changed during a query scan");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntLast)
    else $error("scan counter out of range");

  a_max_ge_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == swmm_pkg::ST_SCAN) && (cnt_q != '0)) |-> (max_q >= min_q))
    else $error("running max below running min");

  a_load_only_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> (!out_valid_q || out_ready_i))
    else $error("result loaded over a waiting word");

endmodule

FILE: dv/testbench.sv
// self-checking testbench for the sliding window min/max/mean block
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned WinDepth  = 16;
  localparam int unsigned FracScale = 16;
  localparam logic [swmm_pkg::CodeBits-1:0] FullScale = '1;
  localparam int unsigned RunWords  = 1850;
  localparam int unsigned SteadyLo  = 700;
  localparam int unsigned SteadyHi  = 1000;
  localparam int unsigned DrainAt   = 1300;

  // tracks the window contents and the statistics each query must return
  class window_scoreboard;
    logic [swmm_pkg::CodeBits-1:0] cells[WinDepth];
    logic [swmm_pkg::MeanBits-1:0] sum;
    swmm_pkg::swmm_out_t           stats_q[$];
    int unsigned                   errors;
    int unsigned                   results_checked;

    function new();
      foreach (cells[k]) cells[k] = '0;
      sum = '0;
      errors = 0;
      results_checked = 0;
    endfunction

    function void note_input(swmm_pkg::swmm_in_t w);
      logic [swmm_pkg::CodeBits-1:0] code;
      logic [swmm_pkg::CodeBits-1:0] hi;
      logic [swmm_pkg::CodeBits-1:0] lo;
      longint unsigned               mean;
      swmm_pkg::swmm_out_t           stats;
      if (w.cmd == swmm_pkg::CMD_SAMPLE) begin
        // top two codes read as full scale
        code = (w.sample_code >= FullScale - 12'd1) ? FullScale : w.sample_code;
        sum = sum - 16'(cells[0]);
        for (int k = 0; k < WinDepth - 1; k++) cells[k] = cells[k+1];
        cells[WinDepth-1] = code;
        sum = sum + 16'(code);
      end else begin
        hi = cells[0];
        lo = cells[0];
        for (int k = 1; k < WinDepth; k++) begin
          if (cells[k] > hi) hi = cells[k];
          if (cells[k] < lo) lo = cells[k];
        end
        mean = (longint'(sum) * FracScale) / WinDepth;
        if (mean > 64'hFFFF) mean = 64'hFFFF;
        stats.mean_code = mean[swmm_pkg::MeanBits-1:0];
        stats.max_code  = hi;
        stats.min_code  = lo;
        stats_q.push_back(stats);
      end
    endfunction

    function void check_result(swmm_pkg::swmm_out_t got);
      swmm_pkg::swmm_out_t exp_stats;
      results_checked++;
      if (stats_q.size() == 0) begin
        $error("result with no query pending: mean %0d max %0d min %0d",
               got.mean_code, got.max_code, got.min_code);
        errors++;
        return;
      end
      exp_stats = stats_q.pop_front();
      if (got.mean_code !== exp_stats.mean_code) begin
        $error("mean_code: expected %0d, got %0d", exp_stats.mean_code, got.mean_code);
        errors++;
      end
      if (got.max_code !== exp_stats.max_code) begin
        $error("max_code: expected %0d, got %0d", exp_stats.max_code, got.max_code);
        errors++;
      end
      if (got.min_code !== exp_stats.min_code) begin
        $error("min_code: expected %0d, got %0d", exp_stats.min_code, got.min_code);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return stats_q.size();
    endfunction
  endclass

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  swmm_pkg::swmm_in_t  in_data_i   = '0;
  logic                out_ready_i = 1'b0;
  logic                in_ready_o;
  logic                out_valid_o;
  swmm_pkg::swmm_out_t out_data_o;

  window_scoreboard sb = new();
  int unsigned words_sent = 0;

  sliding_window_min_max_mean u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always #6 clk_i = ~clk_i;

  function automatic logic [swmm_pkg::CodeBits-1:0] pick_code();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 55) return 12'($urandom_range(0, 4095));
    if (sel < 70) return 12'(4095 - $urandom_range(0, 3));
    if (sel < 85) return 12'($urandom_range(0, 3));
    return $urandom_range(0, 1) ? 12'hAAA : 12'h555;
  endfunction

  task automatic send_word(logic cmd, logic [swmm_pkg::CodeBits-1:0] code);
    swmm_pkg::swmm_in_t w;
    w.cmd = cmd;
    w.sample_code = code;
    if (words_sent == DrainAt) begin
      // let every pending query come back before going on
      in_valid_i <= 1'b0;
      while (sb.pending() != 0) @(posedge clk_i);
      repeat (4) @(posedge clk_i);
    end else if (!(words_sent >= SteadyLo && words_sent < SteadyHi) &&
                 $urandom_range(0, 99) < 20) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(w);
    words_sent++;
  endtask

  // result side: random stalls, one long hold-off, one stretch without stalls
  initial begin : result_side
    int unsigned cyc;
    int unsigned hold_left;
    bit          hold_done;
    cyc = 0;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk_i);
      cyc++;
      if (out_valid_o && out_ready_i) sb.check_result(out_data_o);
      if (!hold_done && sb.results_checked == 30) begin
        hold_left = 400;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (cyc >= 2500 && cyc < 4000) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= 17);
      end
    end
  end

  initial begin : word_source
    int unsigned kind;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty window, clamp edges, bit patterns, back-to-back queries
    send_word(swmm_pkg::CMD_QUERY, 12'hFFF);
    send_word(swmm_pkg::CMD_SAMPLE, 12'd4093);
    send_word(swmm_pkg::CMD_SAMPLE, 12'd4094);
    send_word(swmm_pkg::CMD_SAMPLE, 12'd4095);
    send_word(swmm_pkg::CMD_SAMPLE, 12'd0);
    send_word(swmm_pkg::CMD_QUERY, 12'h000);
    send_word(swmm_pkg::CMD_SAMPLE, 12'd1);
    send_word(swmm_pkg::CMD_SAMPLE, 12'd2048);
    send_word(swmm_pkg::CMD_SAMPLE, 12'hAAA);
    send_word(swmm_pkg::CMD_SAMPLE, 12'h555);
    send_word(swmm_pkg::CMD_SAMPLE, 12'd4095);
    send_word(swmm_pkg::CMD_QUERY, 12'hAAA);
    send_word(swmm_pkg::CMD_QUERY, 12'h555);

    while (words_sent < RunWords) begin
      kind = $urandom_range(0, 9);
      if (kind <= 5) begin
        repeat ($urandom_range(1, 24)) send_word(swmm_pkg::CMD_SAMPLE, pick_code());
        if ($urandom_range(0, 1)) begin
          send_word(swmm_pkg::CMD_QUERY, 12'($urandom_range(0, 4095)));
        end
      end else if (kind == 6) begin
        // whole window at full scale
        repeat ($urandom_range(16, 20)) begin
          send_word(swmm_pkg::CMD_SAMPLE, 12'(4094 + $urandom_range(0, 1)));
        end
        send_word(swmm_pkg::CMD_QUERY, 12'($urandom_range(0, 4095)));
      end else if (kind == 7) begin
        repeat ($urandom_range(16, 20)) begin
          send_word(swmm_pkg::CMD_SAMPLE, 12'($urandom_range(0, 1)));
        end
        send_word(swmm_pkg::CMD_QUERY, 12'($urandom_range(0, 4095)));
      end else if (kind == 8) begin
        repeat ($urandom_range(2, 5)) begin
          send_word(swmm_pkg::CMD_QUERY, 12'($urandom_range(0, 4095)));
        end
      end else begin
        send_word(swmm_pkg::CMD_SAMPLE, pick_code());
        send_word(swmm_pkg::CMD_QUERY, 12'($urandom_range(0, 4095)));
      end
    end
    in_valid_i <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (24) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #5000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/swmm_pkg.sv
hw/rtl/swmm_cell.sv
hw/rtl/swmm_mean.sv
hw/rtl/sliding_window_min_max_mean.sv
dv/testbench.sv
